@@ sv/afu_pkg.sv @@
// Shared types, constants and elaboration-time functions of the activation function unit.
// Holds the knot-building arithmetic used by afu_pwl. Depends on nothing.
package afu_pkg;

    localparam int SEGMENTS_DEF      = 32;
    localparam int FRACTION_BITS_DEF = 12;
    localparam int SLOPE_BITS        = 12;
    localparam int VALUE_W           = 16;
    localparam int CFG_INDEX_W       = 1;
    localparam int CFG_DATA_W        = 12;

    localparam logic [SLOPE_BITS-1:0] LEAK_DEFAULT = 12'd41;

    localparam logic [CFG_INDEX_W-1:0] CFG_KIND  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLOPE = 1'b1;

    localparam logic CMD_FWD   = 1'b0;
    localparam logic CMD_DERIV = 1'b1;

    typedef enum logic [1:0] {
        KIND_RELU  = 2'd0,
        KIND_LEAKY = 2'd1,
        KIND_TANH  = 2'd2,
        KIND_SIG   = 2'd3
    } t_kind;

    typedef struct packed {
        logic                 is_sig;
        logic                 neg;
        logic [VALUE_W-1:0]   mag;
    } t_pwl_in;

    localparam logic [63:0] Q30_ONE  = 64'd1 << 30;
    localparam logic [63:0] Q30_MASK = Q30_ONE - 64'd1;

    // restoring long division, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // e^f, f in [0, 1], Q30
    function automatic logic [63:0] exp_frac(input logic [63:0] f);
        logic [63:0] term;
        logic [63:0] sum;
        term = Q30_ONE;
        sum  = Q30_ONE;
        for (int i = 1; i <= 24; i++) begin
            term = udiv64((term * f) >> 30, 64'(i));
            sum  = sum + term;
        end
        return sum;
    endfunction

    // sigmoid(x), x >= 0, Q30 in and out
    function automatic logic [63:0] sig_q30(input logic [63:0] x);
        logic [63:0] n;
        logic [63:0] fr;
        logic [63:0] inv_e;
        logic [63:0] em;
        logic [63:0] den;
        n     = x >> 30;
        fr    = x & Q30_MASK;
        den   = exp_frac(Q30_ONE);
        inv_e = udiv64(Q30_ONE << 30, den);
        den   = exp_frac(fr);
        em    = udiv64(Q30_ONE << 30, den);
        for (int i = 0; 64'(i) < n; i++) begin
            em = (em * inv_e) >> 30;
        end
        den = Q30_ONE + em;
        return udiv64(Q30_ONE << 30, den);
    endfunction

    function automatic logic [63:0] to_frac(input logic [63:0] v, input int fb);
        return (v + (64'd1 << (29 - fb))) >> (30 - fb);
    endfunction

endpackage

@@ sv/afu_pwl.sv @@
// Piecewise-linear tanh / sigmoid evaluation on a magnitude, three register stages.
// Knot tables are built at elaboration from afu_pkg functions.
module afu_pwl #(
    parameter int SEGMENTS      = afu_pkg::SEGMENTS_DEF,
    parameter int FRACTION_BITS = afu_pkg::FRACTION_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  afu_pkg::t_pwl_in       i_in,
    output logic [FRACTION_BITS:0] o_val
);

    localparam int KW = FRACTION_BITS + 1;
    localparam int IW = $clog2(SEGMENTS + 1);
    localparam int SH = FRACTION_BITS + 3;
    localparam int PW = afu_pkg::VALUE_W + IW;
    localparam int MW = KW + SH + 1;
    localparam logic [KW-1:0] ONE  = {1'b1, {FRACTION_BITS{1'b0}}};
    localparam logic [IW-1:0] LAST = IW'(SEGMENTS);

    logic [KW-1:0] w_sig_tab  [SEGMENTS+1];
    logic [KW-1:0] w_tanh_tab [SEGMENTS+1];

    for (genvar gk = 0; gk <= SEGMENTS; gk++) begin : g_knot
        localparam logic [63:0] XS  = (64'(gk) << 33) / SEGMENTS;
        localparam logic [63:0] XS2 = (64'(gk) << 34) / SEGMENTS;
        localparam logic [KW-1:0] SIG_K =
            KW'(afu_pkg::to_frac(afu_pkg::sig_q30(XS), FRACTION_BITS));
        localparam logic [KW-1:0] TANH_K = KW'(afu_pkg::to_frac(
            (afu_pkg::sig_q30(XS2) << 1) - afu_pkg::Q30_ONE, FRACTION_BITS));
        assign w_sig_tab[gk]  = SIG_K;
        assign w_tanh_tab[gk] = TANH_K;
    end

    // stage B: segment index and knot lookup
    logic [PW-1:0] w_prod;
    logic [31:0]   w_idx32;
    logic          w_sat;
    logic [IW-1:0] w_idx;
    logic [IW-1:0] w_idx1;
    logic [KW-1:0] w_y0;
    logic [KW-1:0] w_y1;

    always_comb begin
        w_prod  = PW'(i_in.mag) * PW'(SEGMENTS);
        w_idx32 = 32'(w_prod >> SH);
        w_sat   = w_idx32 >= 32'(SEGMENTS);
        w_idx   = w_sat ? LAST : w_idx32[IW-1:0];
        w_idx1  = w_sat ? LAST : IW'(w_idx + IW'(1));
        w_y0    = i_in.is_sig ? w_sig_tab[w_idx]  : w_tanh_tab[w_idx];
        w_y1    = i_in.is_sig ? w_sig_tab[w_idx1] : w_tanh_tab[w_idx1];
    end

    logic [KW-1:0] r_b_y0;
    logic [KW-1:0] r_b_d;
    logic [SH-1:0] r_b_r;
    logic          r_b_mirror;
    logic [KW-1:0] r_c_y0;
    logic [MW-1:0] r_c_mul;
    logic          r_c_mirror;
    logic [KW-1:0] r_d_val;

    // stage D: rounding and mirror for negative sigmoid
    logic [MW-1:0] n_sum;
    logic [KW-1:0] n_t;
    logic [KW-1:0] n_val;

    always_comb begin
        n_sum = r_c_mul + MW'(1 << (SH - 1));
        n_t   = KW'(r_c_y0 + KW'(n_sum >> SH));
        n_val = r_c_mirror ? KW'(ONE - n_t) : n_t;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_y0     <= w_y0;
            r_b_d      <= KW'(w_y1 - w_y0);
            r_b_r      <= w_sat ? '0 : w_prod[SH-1:0];
            r_b_mirror <= i_in.is_sig && i_in.neg;
            r_c_y0     <= r_b_y0;
            r_c_mul    <= MW'(r_b_d) * MW'(r_b_r);
            r_c_mirror <= r_b_mirror;
            r_d_val    <= n_val;
        end
    end

    assign o_val = r_d_val;

endmodule

@@ sv/activation_function_unit.sv @@
// Top level of the activation function unit: handshake, configuration and result stages.
// Depends on afu_pkg and afu_pwl.
//
// Use: one signed element and a command bit enter per beat on i_valid / o_stall;
// one result leaves per beat on o_valid / i_stall. The command picks the forward
// value or the derivative of the function set by register 0 (relu, leaky relu,
// tanh, sigmoid); register 1 holds the leaky slope, unsigned Q0.12.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data; the user
// must do so only while idle, as the block does not enforce it. Throughput: one beat
// per cycle while i_stall does not hold the output. The beat crosses six register stages
// (decode, knot lookup, interpolation multiply, rounding, square, output register) and
// the first of them loads on the edge that takes the input beat.
// Reset clears all valid bits, sets the function to relu and the slope to 41.
// The pipeline advances as one: while the output register holds a beat under
// i_stall, every stage holds and o_stall is raised; nothing is dropped or repeated.
// Tanh and sigmoid saturate at the knot value for magnitudes of 8 and above.
module activation_function_unit #(
    parameter int SEGMENTS      = afu_pkg::SEGMENTS_DEF,
    parameter int FRACTION_BITS = afu_pkg::FRACTION_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [afu_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [afu_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_command,
    input  logic signed [afu_pkg::VALUE_W-1:0]  i_input_value,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [afu_pkg::VALUE_W-1:0]  o_result_value
);

    localparam int KW = FRACTION_BITS + 1;
    localparam int RW = afu_pkg::VALUE_W + 2;
    localparam int SB = afu_pkg::SLOPE_BITS;
    localparam int LW = afu_pkg::VALUE_W + SB;
    localparam int NS = 5;
    localparam logic [KW-1:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};
    localparam logic signed [RW-1:0] ONE_R   = RW'(ONE);
    localparam logic signed [RW-1:0] RES_MAX = RW'(32767);
    localparam logic signed [RW-1:0] RES_MIN = -RW'(32768);

    typedef struct packed {
        logic                                cmd;
        afu_pkg::t_kind                      kind;
        logic signed [afu_pkg::VALUE_W-1:0]  x;
        logic [afu_pkg::VALUE_W-1:0]         mag;
        logic [LW-1:0]                       leak;
    } t_side;

    // configuration
    afu_pkg::t_kind  r_kind;
    logic [SB-1:0]   r_slope;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind  <= afu_pkg::KIND_RELU;
            r_slope <= afu_pkg::LEAK_DEFAULT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                afu_pkg::CFG_KIND:  r_kind  <= afu_pkg::t_kind'(i_cfg_data[1:0]);
                afu_pkg::CFG_SLOPE: r_slope <= i_cfg_data[SB-1:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic          w_en;
    logic [NS-1:0] r_vld;
    logic          r_out_valid;

    assign w_en    = !(r_out_valid && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_vld       <= {r_vld[NS-2:0], i_valid};
            r_out_valid <= r_vld[NS-1];
        end
    end

    // stage A decode
    t_side n_side;

    always_comb begin
        n_side      = '0;
        n_side.cmd  = i_command;
        n_side.kind = r_kind;
        n_side.x    = i_input_value;
        n_side.mag  = i_input_value[afu_pkg::VALUE_W-1]
                      ? (afu_pkg::VALUE_W)'(-i_input_value) : i_input_value;
    end

    t_side r_sd [NS];
    t_side n_sd1;

    // leaky magnitude product joins the side data at stage B
    always_comb begin
        n_sd1      = r_sd[0];
        n_sd1.leak = LW'(r_sd[0].mag) * LW'(r_slope);
    end

    afu_pkg::t_pwl_in      w_pwl_in;
    logic [KW-1:0]         w_pwl_val;

    assign w_pwl_in.is_sig = r_sd[0].kind == afu_pkg::KIND_SIG;
    assign w_pwl_in.neg    = r_sd[0].x[afu_pkg::VALUE_W-1];
    assign w_pwl_in.mag    = r_sd[0].mag;

    afu_pwl #(
        .SEGMENTS      (SEGMENTS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_pwl (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_in  (w_pwl_in),
        .o_val (w_pwl_val)
    );

    logic [KW-1:0]   r_v;
    logic [2*KW-1:0] r_sq;

    // final stage
    logic [2*KW:0]              w_sq_sum;
    logic [KW:0]                w_sqf;
    logic [LW:0]                w_leak_sum;
    logic [afu_pkg::VALUE_W:0]  w_leak_mag;
    logic [SB+FRACTION_BITS:0]  w_slope_sum;
    logic [KW-1:0]              w_slope_d;
    logic signed [RW-1:0]       w_x;
    logic                       w_pos;
    logic                       w_neg;
    logic signed [RW-1:0]       n_res;
    logic signed [afu_pkg::VALUE_W-1:0] n_result;
    logic signed [afu_pkg::VALUE_W-1:0] r_result;

    always_comb begin
        w_sq_sum    = (2*KW+1)'(r_sq) + (2*KW+1)'(1 << (FRACTION_BITS - 1));
        w_sqf       = (KW+1)'(w_sq_sum >> FRACTION_BITS);
        w_leak_sum  = (LW+1)'(r_sd[NS-1].leak) + (LW+1)'(1 << (SB - 1));
        w_leak_mag  = (afu_pkg::VALUE_W+1)'(w_leak_sum >> SB);
        w_slope_sum = ((SB+FRACTION_BITS+1)'(r_slope) << FRACTION_BITS)
                      + (SB+FRACTION_BITS+1)'(1 << (SB - 1));
        w_slope_d   = KW'(w_slope_sum >> SB);
        w_x         = RW'(r_sd[NS-1].x);
        w_neg       = r_sd[NS-1].x[afu_pkg::VALUE_W-1];
        w_pos       = !w_neg && (r_sd[NS-1].x != '0);
        n_res       = '0;
        case (r_sd[NS-1].kind)
            afu_pkg::KIND_RELU: begin
                if (r_sd[NS-1].cmd == afu_pkg::CMD_DERIV) begin
                    n_res = w_pos ? ONE_R : '0;
                end else begin
                    n_res = w_pos ? w_x : '0;
                end
            end
            afu_pkg::KIND_LEAKY: begin
                if (r_sd[NS-1].cmd == afu_pkg::CMD_DERIV) begin
                    n_res = w_pos ? ONE_R : RW'(w_slope_d);
                end else begin
                    n_res = w_neg ? -RW'(w_leak_mag) : w_x;
                end
            end
            afu_pkg::KIND_TANH: begin
                if (r_sd[NS-1].cmd == afu_pkg::CMD_DERIV) begin
                    n_res = ONE_R - RW'(w_sqf);
                end else begin
                    n_res = w_neg ? -RW'(r_v) : RW'(r_v);
                end
            end
            afu_pkg::KIND_SIG: begin
                if (r_sd[NS-1].cmd == afu_pkg::CMD_DERIV) begin
                    n_res = RW'(r_v) - RW'(w_sqf);
                end else begin
                    n_res = RW'(r_v);
                end
            end
            default: n_res = '0;
        endcase
        if (n_res > RES_MAX) begin
            n_result = RES_MAX[afu_pkg::VALUE_W-1:0];
        end else if (n_res < RES_MIN) begin
            n_result = RES_MIN[afu_pkg::VALUE_W-1:0];
        end else begin
            n_result = n_res[afu_pkg::VALUE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sd[0] <= n_side;
            r_sd[1] <= n_sd1;
            for (int i = 2; i < NS; i++) begin
                r_sd[i] <= r_sd[i-1];
            end
            r_v      <= w_pwl_val;
            r_sq     <= (2*KW)'(w_pwl_val) * (2*KW)'(w_pwl_val);
            r_result <= n_result;
        end
    end

    assign o_result_value = r_result;

    // checks
    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> $stable(r_vld))
        else $error("pipeline moved while output held");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted beat lost at entry");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_pwl_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NS-1] |-> (r_v <= ONE))
        else $error("table value above one");

endmodule
